@@ rtl/core/lpg_pkg.sv @@
package lpg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_W          = 12;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_VERT  = 2'd1,
    KIND_HORZ  = 2'd2,
    KIND_DIAG  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_MAIN  = 2'd0,
    PH_EXTRA = 2'd1,
    PH_FINAL = 2'd2
  } phase_t;

endpackage

@@ rtl/core/line_pixel_generator_top.sv @@
// Line pixel generator.
// A start item (in_tuser = 0) loads two endpoints and a color and gives no
// result. Each step item (in_tuser = 1) gives the next pixel write of that
// line on the out_ channel; out_tlast marks the write at the end point,
// after which further steps give nothing until the next start. A start
// during a line drops the old line.
// Screen width and height are written on the cfg_ port; the user must do
// so only while the block is idle (not enforced by the block); out_tuser
// flags writes that fall inside the screen. A result appears on out_tvalid
// in the cycle after its step item is accepted. Throughput: one item per
// cycle while in_tready is high; the line state update is combinational.
// The result register holds a write until taken; in_tready stays high
// while that register is empty or being drained, so a stalled receiver
// stops input only once a result is waiting.
// Reset: no line in progress, no result pending, width 640, height 480.
module line_pixel_generator_top #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
  localparam int IN_DW  = ((4 * COORD_BITS + 32 + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [lpg_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // x_start, y_start, x_end, y_end, line_color (from bit 0 up), zero pad
  input  logic [IN_DW-1:0]          in_tdata,
  // operation
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // pixel_x, pixel_y, pixel_color (from bit 0 up), zero pad
  output logic [OUT_DW-1:0]         out_tdata,
  // visible
  output logic                      out_tuser,
  output logic                      out_tlast
);
  import lpg_pkg::*;

  localparam int C  = COORD_BITS;

  logic [CFG_W-1:0] width_r, height_r;

  logic             active_r, active_nxt;
  kind_t            kind_r, kind_nxt;
  phase_t           phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic             ymaj_r, ymaj_nxt;
  logic [C-1:0]     cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [C-1:0]     tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [C:0]       major_r, major_nxt, minor_r, minor_nxt;
  logic [C:0]       err_r, err_nxt;
  logic [31:0]      color_r, color_nxt;

  logic             out_valid_r;
  logic [C-1:0]     ox_r, oy_r;
  logic [31:0]      ocolor_r;
  logic             ovis_r, olast_r;

  logic             accept, emit;
  logic signed [C-1:0] xs, ys, xe, ye;
  logic signed [C:0]   ddx, ddy;
  logic [C:0]       adx, ady;
  logic             x_major, swap;
  logic [C-1:0]     sx1, sy1, sx2, sy2;
  logic [C-1:0]     step_v;
  logic [C+1:0]     err_sum;
  logic [C-1:0]     ex, ey;
  logic             elast, evis;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign emit      = accept && (in_tuser == OP_STEP) && active_r;

  assign xs = in_tdata[C-1:0];
  assign ys = in_tdata[2*C-1:C];
  assign xe = in_tdata[3*C-1:2*C];
  assign ye = in_tdata[4*C-1:3*C];

  assign ddx     = {xe[C-1], xe} - {xs[C-1], xs};
  assign ddy     = {ye[C-1], ye} - {ys[C-1], ys};
  assign adx     = ddx[C] ? (C+1)'(-ddx) : ddx;
  assign ady     = ddy[C] ? (C+1)'(-ddy) : ddy;
  assign x_major = adx >= ady;
  assign swap    = x_major ? (xe < xs) : (ye < ys);
  assign sx1     = swap ? xe : xs;
  assign sy1     = swap ? ye : ys;
  assign sx2     = swap ? xs : xe;
  assign sy2     = swap ? ys : ye;

  assign step_v  = neg_r ? {C{1'b1}} : {{(C-1){1'b0}}, 1'b1};
  assign err_sum = {1'b0, err_r} + {1'b0, minor_r};

  // emitted coordinates and clip test
  assign elast = (phase_r == PH_FINAL);
  assign ex    = elast ? tgt_x_r : cur_x_r;
  assign ey    = elast ? tgt_y_r : cur_y_r;
  assign evis  = !ex[C-1] && !ey[C-1]
              && ({{CFG_W{1'b0}}, ex} < {{C{1'b0}}, width_r})
              && ({{CFG_W{1'b0}}, ey} < {{C{1'b0}}, height_r});

  always_comb begin
    active_nxt = active_r;
    kind_nxt   = kind_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    ymaj_nxt   = ymaj_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    if (accept && in_tuser == OP_START) begin
      active_nxt = 1'b1;
      color_nxt  = in_tdata[4*C+31:4*C];
      err_nxt    = '0;
      major_nxt  = x_major ? adx : ady;
      minor_nxt  = x_major ? ady : adx;
      ymaj_nxt   = !x_major;
      phase_nxt  = PH_MAIN;
      cur_x_nxt  = xs;
      cur_y_nxt  = ys;
      tgt_x_nxt  = xe;
      tgt_y_nxt  = ye;
      if (xs == xe && ys == ye) begin
        kind_nxt  = KIND_POINT;
        phase_nxt = PH_FINAL;
        neg_nxt   = 1'b0;
      end else if (xs == xe) begin
        kind_nxt = KIND_VERT;
        neg_nxt  = ys > ye;
      end else if (ys == ye) begin
        kind_nxt = KIND_HORZ;
        neg_nxt  = xs > xe;
      end else begin
        kind_nxt  = KIND_DIAG;
        cur_x_nxt = sx1;
        cur_y_nxt = sy1;
        tgt_x_nxt = sx2;
        tgt_y_nxt = sy2;
        neg_nxt   = x_major ? ($signed(sy2) < $signed(sy1))
                            : ($signed(sx2) < $signed(sx1));
      end
    end else if (emit) begin
      if (phase_r == PH_FINAL) begin
        active_nxt = 1'b0;
        phase_nxt  = PH_MAIN;
      end else begin
        case (kind_r)
          KIND_VERT: begin
            cur_y_nxt = cur_y_r + step_v;
            if (cur_y_nxt == tgt_y_r) phase_nxt = PH_FINAL;
          end
          KIND_HORZ: begin
            cur_x_nxt = cur_x_r + step_v;
            if (cur_x_nxt == tgt_x_r) phase_nxt = PH_FINAL;
          end
          KIND_DIAG: begin
            if (phase_r == PH_MAIN && err_sum >= {1'b0, major_r}) begin
              // error wrapped: step minor axis, extra write there
              err_nxt   = (C+1)'(err_sum - {1'b0, major_r});
              phase_nxt = PH_EXTRA;
              if (ymaj_r) cur_x_nxt = cur_x_r + step_v;
              else        cur_y_nxt = cur_y_r + step_v;
            end else begin
              if (phase_r == PH_MAIN) err_nxt = err_sum[C:0];
              phase_nxt = PH_MAIN;
              if (ymaj_r) begin
                if (cur_y_r == tgt_y_r) phase_nxt = PH_FINAL;
                else cur_y_nxt = cur_y_r + {{(C-1){1'b0}}, 1'b1};
              end else begin
                if (cur_x_r == tgt_x_r) phase_nxt = PH_FINAL;
                else cur_x_nxt = cur_x_r + {{(C-1){1'b0}}, 1'b1};
              end
            end
          end
          default: phase_nxt = PH_FINAL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      active_r    <= 1'b0;
      kind_r      <= KIND_POINT;
      phase_r     <= PH_MAIN;
      neg_r       <= 1'b0;
      ymaj_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default:    ;
        endcase
      end
      active_r <= active_nxt;
      kind_r   <= kind_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      ymaj_r   <= ymaj_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    tgt_x_r <= tgt_x_nxt;
    tgt_y_r <= tgt_y_nxt;
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    err_r   <= err_nxt;
    color_r <= color_nxt;
    if (emit) begin
      ox_r     <= ex;
      oy_r     <= ey;
      ocolor_r <= color_r;
      ovis_r   <= evis;
      olast_r  <= elast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({ocolor_r, oy_r, ox_r});
  assign out_tuser  = ovis_r;
  assign out_tlast  = olast_r;

  a_final_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    emit && phase_r == PH_FINAL |=> out_valid_r && out_tlast && !active_r)
    else $error("final write did not end the line");

  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == OP_START |=>
      out_valid_r == $past(out_valid_r && !out_tready))
    else $error("start item changed the result register");

  a_err_below_major: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && kind_r == KIND_DIAG |-> err_r < major_r)
    else $error("error term not below major delta");

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> phase_r == PH_MAIN)
    else $error("idle with a pending walk phase");

endmodule

@@ sim/line_pixel_generator_top_tb.sv @@
module line_pixel_generator_top_tb;
  import lpg_pkg::*;

  localparam int CB     = COORD_BITS_DEF;
  localparam int IN_DW  = ((4 * CB + 32 + 7) / 8) * 8;
  localparam int OUT_DW = ((2 * CB + 32 + 7) / 8) * 8;
  localparam int CMAX   = 2 ** (CB - 1) - 1;
  localparam int CMIN   = -(2 ** (CB - 1));
  localparam int NO_CAP = 1 << 30;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_LEN    = 300;
  localparam int N_SIZES     = 6;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    op_t              op;
    logic [IN_DW-1:0] data;
  } line_cmd_t;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [31:0]   color;
    logic          vis;
    logic          is_last;
  } pix_write_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata  = '0;
  logic              in_tuser  = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tuser;
  logic              out_tlast;

  line_pixel_generator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  line_cmd_t  line_cmd_q[$];
  pix_write_t pending_writes[$];

  int   n_pushed  = 0;
  int   n_in_acc  = 0;
  int   n_writes  = 0;
  int   n_vis     = 0;
  int   n_lines   = 0;
  int   n_bad     = 0;
  int   quiet     = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic in_took   = 1'b0;
  logic calm      = 1'b0;

  // predictor copy of the line walker and the screen size
  logic [CFG_W-1:0] scr_w, scr_h;
  logic        ln_active;
  kind_t       ln_kind;
  phase_t      ln_phase;
  coord_t      ln_cx, ln_cy, ln_tx, ln_ty;
  int          ln_maj, ln_min, ln_err;
  logic [31:0] ln_color;
  logic        ln_ymaj, ln_neg;

  function automatic pix_write_t make_write(coord_t x, coord_t y, logic is_last);
    pix_write_t w;
    w.x       = x;
    w.y       = y;
    w.color   = ln_color;
    w.vis     = x >= 0 && y >= 0 && int'(x) < int'(scr_w) && int'(y) < int'(scr_h);
    w.is_last = is_last;
    return w;
  endfunction

  task automatic trace_item(input logic op_bit, input logic [IN_DW-1:0] d);
    coord_t x1, y1, x2, y2, sw, stp;
    int     adx, ady;
    logic   wrapped;
    if (op_t'(op_bit) == OP_START) begin
      x1 = d[CB-1:0];
      y1 = d[2*CB-1:CB];
      x2 = d[3*CB-1:2*CB];
      y2 = d[4*CB-1:3*CB];
      ln_color  = d[4*CB +: 32];
      ln_active = 1'b1;
      ln_err    = 0;
      ln_maj    = 0;
      ln_min    = 0;
      ln_ymaj   = 1'b0;
      ln_neg    = 1'b0;
      ln_phase  = PH_MAIN;
      if (x1 == x2 && y1 == y2) begin
        ln_kind  = KIND_POINT;
        ln_phase = PH_FINAL;
      end else if (x1 == x2) begin
        ln_kind = KIND_VERT;
        ln_neg  = y1 > y2;
      end else if (y1 == y2) begin
        ln_kind = KIND_HORZ;
        ln_neg  = x1 > x2;
      end else begin
        adx = (x1 < x2) ? int'(x2) - int'(x1) : int'(x1) - int'(x2);
        ady = (y1 < y2) ? int'(y2) - int'(y1) : int'(y1) - int'(y2);
        ln_kind = KIND_DIAG;
        // swap so the major axis always ascends
        if (adx >= ady) begin
          if (x2 < x1) begin
            sw = x1; x1 = x2; x2 = sw;
            sw = y1; y1 = y2; y2 = sw;
          end
          ln_neg = y2 < y1;
          ln_maj = adx;
          ln_min = ady;
        end else begin
          if (y2 < y1) begin
            sw = x1; x1 = x2; x2 = sw;
            sw = y1; y1 = y2; y2 = sw;
          end
          ln_ymaj = 1'b1;
          ln_neg  = x2 < x1;
          ln_maj  = ady;
          ln_min  = adx;
        end
      end
      ln_cx = x1;
      ln_cy = y1;
      ln_tx = x2;
      ln_ty = y2;
    end else if (ln_active) begin
      if (ln_phase == PH_FINAL) begin
        pending_writes.push_back(make_write(ln_tx, ln_ty, 1'b1));
        ln_active = 1'b0;
        ln_phase  = PH_MAIN;
      end else begin
        stp = ln_neg ? coord_t'(-1) : coord_t'(1);
        pending_writes.push_back(make_write(ln_cx, ln_cy, 1'b0));
        wrapped = 1'b0;
        case (ln_kind)
          KIND_VERT: begin
            ln_cy = ln_cy + stp;
            if (ln_cy == ln_ty) ln_phase = PH_FINAL;
          end
          KIND_HORZ: begin
            ln_cx = ln_cx + stp;
            if (ln_cx == ln_tx) ln_phase = PH_FINAL;
          end
          KIND_DIAG: begin
            if (ln_phase == PH_MAIN) begin
              ln_err += ln_min;
              if (ln_err >= ln_maj) begin
                // error wrap: minor axis steps, next write is the extra pixel
                ln_err -= ln_maj;
                wrapped = 1'b1;
                if (ln_ymaj) ln_cx = ln_cx + stp;
                else ln_cy = ln_cy + stp;
                ln_phase = PH_EXTRA;
              end
            end
            if (!wrapped) begin
              if (ln_ymaj ? ln_cy == ln_ty : ln_cx == ln_tx) begin
                ln_phase = PH_FINAL;
              end else begin
                if (ln_ymaj) ln_cy = ln_cy + coord_t'(1);
                else ln_cx = ln_cx + coord_t'(1);
                ln_phase = PH_MAIN;
              end
            end
          end
          default: ln_phase = PH_FINAL;
        endcase
      end
    end
  endtask

  task automatic flag_bad(input string msg);
    n_bad++;
    if (n_bad <= 10) $display("mismatch @%0t: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) flag_bad($sformatf("%s expected %h got %h", name, exp_v, act_v));
  endtask

  // monitor: runs the predictor on accepted items and checks every pixel write
  always @(posedge clk) begin : watch_out
    pix_write_t w;
    if (!rst_n) begin
      scr_w     = WIDTH_RST;
      scr_h     = HEIGHT_RST;
      ln_active = 1'b0;
      ln_kind   = KIND_POINT;
      ln_phase  = PH_MAIN;
      ln_cx     = '0;
      ln_cy     = '0;
      ln_tx     = '0;
      ln_ty     = '0;
      ln_maj    = 0;
      ln_min    = 0;
      ln_err    = 0;
      ln_color  = '0;
      ln_ymaj   = 1'b0;
      ln_neg    = 1'b0;
    end else begin
      if (cfg_we) begin
        if (reg_idx_t'(cfg_index) == REG_WIDTH) scr_w = cfg_wdata;
        else scr_h = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        n_writes++;
        if (out_tuser) n_vis++;
        if (out_tlast) n_lines++;
        if (pending_writes.size() == 0) begin
          flag_bad($sformatf("pixel write with none pending, tdata %h", out_tdata));
        end else begin
          w = pending_writes.pop_front();
          cmp_field("pixel_x", 32'(w.x), 32'(out_tdata[CB-1:0]));
          cmp_field("pixel_y", 32'(w.y), 32'(out_tdata[2*CB-1:CB]));
          cmp_field("pixel_color", w.color, out_tdata[2*CB +: 32]);
          cmp_field("visible", 32'(w.vis), 32'(out_tuser));
          cmp_field("last_pixel", 32'(w.is_last), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        n_in_acc++;
        trace_item(in_tuser, in_tdata);
      end
    end
    in_took <= rst_n && in_tvalid && in_tready;
  end

  // input driver
  always @(negedge clk) begin : drive_in
    line_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (line_cmd_q.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        c = line_cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= c.op;
        in_tdata  <= c.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off so the output register backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && n_in_acc >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || $urandom_range(99) >= 11;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("line_pixel_generator_top test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_step();
    line_cmd_t c;
    c.op   = OP_STEP;
    c.data = IN_DW'({$urandom, $urandom, $urandom});
    line_cmd_q.push_back(c);
    n_pushed++;
  endtask

  // start a line, then enough steps to finish it (adjusted by tweak, capped)
  task automatic push_line(input coord_t xs, ys, xe, ye, input logic [31:0] color,
                           input int tweak, input int cap);
    line_cmd_t c;
    int adx, ady, mj, mn, n;
    adx = (xs < xe) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
    ady = (ys < ye) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
    if (adx == 0 && ady == 0) begin
      n = 1;
    end else if (adx == 0 || ady == 0) begin
      n = adx + ady + 1;
    end else begin
      mj = (adx >= ady) ? adx : ady;
      mn = (adx >= ady) ? ady : adx;
      // every major position, one extra per error wrap, then the end point
      n = mj + 2 + (mj + 1) * mn / mj;
    end
    n = n + tweak;
    if (n > cap) n = cap;
    c.op   = OP_START;
    c.data = IN_DW'({color, ye, xe, ys, xs});
    line_cmd_q.push_back(c);
    n_pushed++;
    repeat (n) push_step();
  endtask

  function automatic coord_t near(input int c, input int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return coord_t'(v);
  endfunction

  task automatic random_lines(input int w, input int h, input int items);
    int goal, r, t, cxv, cyv, span;
    coord_t xs, ys, xe, ye;
    goal = n_pushed + items;
    while (n_pushed < goal) begin
      r = $urandom_range(99);
      if (r < 5) begin
        repeat ($urandom_range(1, 2)) push_step();
      end else if (r < 11) begin
        // anywhere in the coordinate range, cut short by the next start
        push_line(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                  $urandom, 0, $urandom_range(1, 6));
      end else begin
        cxv  = int'($urandom_range(0, w + 48)) - 24;
        cyv  = int'($urandom_range(0, h + 48)) - 24;
        span = ($urandom_range(7) == 0) ? 40 : 6;
        xs = near(cxv, span);
        ys = near(cyv, span);
        xe = near(cxv, span);
        ye = near(cyv, span);
        case ($urandom_range(7))
          0: xe = xs;
          1: ye = ys;
          2: begin
            xe = xs;
            ye = ys;
          end
          default: ;
        endcase
        t = $urandom_range(9);
        push_line(xs, ys, xe, ye, $urandom,
                  (t == 0) ? -int'($urandom_range(1, 4)) : ((t == 1) ? 1 : 0), NO_CAP);
      end
    end
    // a single point closes any line left open
    push_line(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0), $urandom, 0, NO_CAP);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (n_in_acc != n_pushed || pending_writes.size() != 0) @(negedge clk);
    // a trailing start gives no write; let it settle
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int ws[N_SIZES];
    int hs[N_SIZES];
    int p;
    ws = '{1, 2048, 0, 4095, 640, 0};
    hs = '{1, 2048, 0, 4095, 480, 0};
    ws[N_SIZES-1] = $urandom_range(1, 2048);
    hs[N_SIZES-1] = $urandom_range(1, 2048);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // point, then one step with nothing in progress
    push_line(coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0),
              32'hFFFF_FFFF, 1, NO_CAP);
    // vertical walking down
    push_line(coord_t'(5), coord_t'(2), coord_t'(5), coord_t'(0),
              32'h0000_0000, 0, NO_CAP);
    // horizontal crossing the right edge on the bottom row
    push_line(coord_t'(638), coord_t'(479), coord_t'(640), coord_t'(479),
              32'hA5A5_5A5A, 0, NO_CAP);
    // y-major at the range extremes with the minor axis descending
    push_line(coord_t'(2047), coord_t'(-2048), coord_t'(2046), coord_t'(-2046),
              32'h1234_5678, 0, NO_CAP);
    // swapped diagonal, dropped after two writes by a new start
    push_line(coord_t'(1), coord_t'(0), coord_t'(0), coord_t'(1),
              32'h0F0F_0F0F, -3, NO_CAP);
    // diagonal whose minor step overshoots past the top and wraps
    push_line(coord_t'(2046), coord_t'(2046), coord_t'(2047), coord_t'(2047),
              32'hDEAD_BEEF, 0, NO_CAP);
    wait_drain();

    for (p = 0; p < N_SIZES; p++) begin
      write_reg(REG_WIDTH, ws[p]);
      write_reg(REG_HEIGHT, hs[p]);
      calm <= (p == 1);
      random_lines(ws[p], hs[p], 80);
      wait_drain();
    end

    $display("covered %0d items in, %0d pixel writes (%0d visible, %0d line ends)",
             n_in_acc, n_writes, n_vis, n_lines);
    $display("over %0d screen sizes incl. zero and full range, with one long output stall",
             N_SIZES + 1);
    if (n_bad == 0 && pending_writes.size() == 0) begin
      $display("line_pixel_generator_top test passed");
    end else begin
      $display("line_pixel_generator_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lpg_pkg.sv
rtl/core/line_pixel_generator_top.sv
sim/line_pixel_generator_top_tb.sv
